// ===== hw/rtl/bap_pkg.sv =====
// Package with payload types, register indexes and reset values for the block averager.
`default_nettype none
package bap_pkg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [10:0] block_col;
        logic [10:0] block_row;
        logic [6:0]  block_width;
        logic [6:0]  block_height;
        logic [7:0]  avg_blue;
        logic [7:0]  avg_green;
        logic [7:0]  avg_red;
        logic        frame_done;
    } block_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BLOCK_SIZE   = 2'd2
    } reg_index_t;

    localparam logic [11:0] RESET_WIDTH  = 12'd1280;
    localparam logic [11:0] RESET_HEIGHT = 12'd720;
    localparam logic [6:0]  RESET_BLOCK  = 7'd10;

    localparam int SUM_W   = 20;
    localparam int COUNT_W = 13;

    // Request from the accumulator to the divider.
    typedef struct packed {
        logic [SUM_W-1:0]   sum_blue;
        logic [SUM_W-1:0]   sum_green;
        logic [SUM_W-1:0]   sum_red;
        logic [COUNT_W-1:0] count;
        block_t             info;
    } div_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/block_average_pixelation.sv =====
// Top level of the block-average pixelation stage: registers, accumulator, divider, output.
//
//  channel | direction | handshake          | payload
//  pix     | in        | pix_valid/pix_stall| bap_pkg::pixel_t
//  blk     | out       | blk_valid/blk_stall| bap_pkg::block_t
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A pixel is taken, walks its position modulo block_size, reads the sum memory and writes it
// back; the modulo is found by repeated subtraction, so for wide frames with small blocks that
// walk dominates. A finishing pixel then hands its sums over to the divider, which divides;
// then the output is loaded and the result waits until taken; pixel input is stalled throughout.
// Reset clears position and control; the sum memory is not cleared and is written first.
// A stalled result holds off the next pixel; register writes wait until no pixel is in flight.
`default_nettype none
module block_average_pixelation #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_BLOCK  = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pix_valid,
    output logic                 pix_stall,
    input  wire bap_pkg::pixel_t pix,
    output logic                 blk_valid,
    input  wire logic            blk_stall,
    output bap_pkg::block_t      blk,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [11:0]     cfg_data
);
    logic [11:0] width_reg, height_reg;
    logic [6:0]  bsize_reg;

    logic              acc_busy, req_valid, div_busy, div_done;
    bap_pkg::div_req_t req;
    bap_pkg::block_t   div_res;
    logic              hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bap_pkg::RESET_WIDTH;
            height_reg <= bap_pkg::RESET_HEIGHT;
            bsize_reg  <= bap_pkg::RESET_BLOCK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bap_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                bap_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                bap_pkg::REG_BLOCK_SIZE:   bsize_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end
    // The accumulator reads the registers for the whole of a pixel's walk.
    assign cfg_ready = !acc_busy;

    // Keep pixels out while the accumulator is busy, while the divider or output still holds an
    // earlier block, and while a register write is offered.
    logic in_take;
    assign pix_stall = acc_busy || req_valid || div_busy || div_done || hold_reg || cfg_valid;
    assign in_take   = pix_valid && !pix_stall;

    bap_accum #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .pix         (pix),
        .frame_width (width_reg),
        .frame_height(height_reg),
        .block_size  (bsize_reg),
        .phase_busy  (acc_busy),
        .req_valid   (req_valid),
        .req         (req)
    );

    bap_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (req_valid),
        .req   (req),
        .busy  (div_busy),
        .done  (div_done),
        .result(div_res)
    );

    bap_pkg::block_t blk_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else if (div_done)
            hold_reg <= 1'b1;
        else if (!blk_stall)
            hold_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (div_done)
            blk_reg <= div_res;
    end

    assign blk_valid = hold_reg;
    assign blk       = blk_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/bap_divider.sv =====
// Restoring divider for the three channel means with round-half-even and saturation.
`default_nettype none
module bap_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bap_pkg::div_req_t req,
    output logic                   busy,
    output logic                   done,
    output bap_pkg::block_t        result
);
    localparam int SW = bap_pkg::SUM_W;
    localparam int CW = bap_pkg::COUNT_W;

    logic              busy_reg;
    logic [4:0]        step_reg;
    logic [SW-1:0]     num_reg [3];
    logic [SW-1:0]     quo_reg [3];
    logic [CW:0]       rem_reg [3];
    logic [CW-1:0]     den_reg;
    bap_pkg::block_t   info_reg;
    logic              done_reg;

    logic [CW:0]       trial [3];
    logic [CW+1:0]     twice [3];
    logic [SW-1:0]     qr    [3];
    logic [7:0]        avg   [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            trial[c] = {rem_reg[c][CW-1:0], num_reg[c][SW-1]};
            twice[c] = {rem_reg[c], 1'b0};
            qr[c]    = quo_reg[c];
            if (twice[c] > {2'b0, den_reg} ||
                (twice[c] == {2'b0, den_reg} && quo_reg[c][0]))
                qr[c] = quo_reg[c] + SW'(1);
            avg[c] = (qr[c] > SW'(255)) ? 8'd255 : qr[c][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg   <= 1'b1;
                step_reg   <= '0;
                num_reg[0] <= req.sum_blue;
                num_reg[1] <= req.sum_green;
                num_reg[2] <= req.sum_red;
                for (int c = 0; c < 3; c++)
                begin
                    quo_reg[c] <= '0;
                    rem_reg[c] <= '0;
                end
                den_reg  <= req.count;
                info_reg <= req.info;
            end
            else if (busy_reg)
            begin
                if (step_reg == 5'(SW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 5'd1;
                    for (int c = 0; c < 3; c++)
                    begin
                        num_reg[c] <= {num_reg[c][SW-2:0], 1'b0};
                        if (trial[c] >= {1'b0, den_reg})
                        begin
                            rem_reg[c] <= trial[c] - {1'b0, den_reg};
                            quo_reg[c] <= {quo_reg[c][SW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[c] <= trial[c];
                            quo_reg[c] <= {quo_reg[c][SW-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        result           = info_reg;
        result.avg_blue  = avg[0];
        result.avg_green = avg[1];
        result.avg_red   = avg[2];
    end

    assign busy = busy_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/bap_accum.sv =====
// Position tracking and per-block-column sum memory with read-modify-write.
`default_nettype none
module bap_accum #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_BLOCK  = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_take,
    input  wire bap_pkg::pixel_t   pix,
    input  wire logic [11:0]       frame_width,
    input  wire logic [11:0]       frame_height,
    input  wire logic [6:0]        block_size,
    output logic                   phase_busy,
    output logic                   req_valid,
    output bap_pkg::div_req_t      req
);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);
    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int SW = bap_pkg::SUM_W;

    logic [SW-1:0] mem_b [MAX_WIDTH];
    logic [SW-1:0] mem_g [MAX_WIDTH];
    logic [SW-1:0] mem_r [MAX_WIDTH];

    // Sequencer: ST_IDLE takes a pixel, ST_DIVMOD walks the position modulo block size,
    // ST_READ waits for the memory, ST_WRITE adds and writes back.
    typedef enum logic [1:0] {ST_IDLE, ST_DIVMOD, ST_READ, ST_WRITE} state_t;
    state_t state_reg;

    logic [XW-1:0] px_reg, ox_reg, colq_reg;
    logic [YW-1:0] py_reg, oy_reg, rowq_reg;
    bap_pkg::pixel_t pix_reg;
    logic [SW-1:0] rb_reg, rg_reg, rr_reg;
    logic req_valid_reg;
    bap_pkg::div_req_t req_reg;

    logic [XW-1:0] w_c;
    logic [YW-1:0] h_c;
    logic [BW-1:0] bs_c;
    always_comb
    begin
        w_c  = (frame_width == 12'd0) ? XW'(1) :
               ({1'b0, frame_width} > 13'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(frame_width);
        h_c  = (frame_height == 12'd0) ? YW'(1) :
               ({1'b0, frame_height} > 13'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(frame_height);
        bs_c = (block_size == 7'd0) ? BW'(1) :
               ({2'b0, block_size} > 9'(MAX_BLOCK)) ? BW'(MAX_BLOCK) : BW'(block_size);
    end

    logic [XW-1:0] x0, bwid, x_rem;
    logic [YW-1:0] y0, bhei, y_rem;
    logic          first_px, last_x, last_y;
    logic [SW-1:0] nb, ng, nr;
    always_comb
    begin
        x0    = px_reg - ox_reg;
        y0    = py_reg - oy_reg;
        x_rem = w_c - x0;
        y_rem = h_c - y0;
        bwid  = (x_rem < XW'(bs_c)) ? x_rem : XW'(bs_c);
        bhei  = (y_rem < YW'(bs_c)) ? y_rem : YW'(bs_c);
        first_px = (ox_reg == '0) && (oy_reg == '0);
        last_x = (ox_reg + XW'(1) == bwid);
        last_y = (oy_reg + YW'(1) == bhei);
        nb = first_px ? SW'(pix_reg.blue)  : rb_reg + SW'(pix_reg.blue);
        ng = first_px ? SW'(pix_reg.green) : rg_reg + SW'(pix_reg.green);
        nr = first_px ? SW'(pix_reg.red)   : rr_reg + SW'(pix_reg.red);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIVMOD && ox_reg < XW'(bs_c) && oy_reg < YW'(bs_c))
        begin
            rb_reg <= mem_b[colq_reg[AW-1:0]];
            rg_reg <= mem_g[colq_reg[AW-1:0]];
            rr_reg <= mem_r[colq_reg[AW-1:0]];
        end
        if (state_reg == ST_WRITE)
        begin
            mem_b[colq_reg[AW-1:0]] <= nb;
            mem_g[colq_reg[AW-1:0]] <= ng;
            mem_r[colq_reg[AW-1:0]] <= nr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            px_reg        <= '0;
            py_reg        <= '0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        pix_reg <= pix;
                        if (pix.frame_start || px_reg >= w_c || py_reg >= h_c)
                        begin
                            px_reg <= '0;
                            py_reg <= '0;
                            ox_reg <= '0;
                            oy_reg <= '0;
                        end
                        else
                        begin
                            ox_reg <= px_reg;
                            oy_reg <= py_reg;
                        end
                        colq_reg  <= '0;
                        rowq_reg  <= '0;
                        state_reg <= ST_DIVMOD;
                    end
                end
                ST_DIVMOD:
                begin
                    // One subtraction per axis per cycle.
                    if (ox_reg >= XW'(bs_c))
                    begin
                        ox_reg   <= ox_reg - XW'(bs_c);
                        colq_reg <= colq_reg + XW'(1);
                    end
                    if (oy_reg >= YW'(bs_c))
                    begin
                        oy_reg   <= oy_reg - YW'(bs_c);
                        rowq_reg <= rowq_reg + YW'(1);
                    end
                    if (ox_reg < XW'(bs_c) && oy_reg < YW'(bs_c))
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (last_x && last_y)
                    begin
                        req_valid_reg                <= 1'b1;
                        req_reg.sum_blue             <= nb;
                        req_reg.sum_green            <= ng;
                        req_reg.sum_red              <= nr;
                        req_reg.count                <= 13'(bwid * bhei);
                        req_reg.info.block_col       <= colq_reg[10:0];
                        req_reg.info.block_row       <= rowq_reg[10:0];
                        req_reg.info.block_width     <= bwid[6:0];
                        req_reg.info.block_height    <= bhei[6:0];
                        req_reg.info.avg_blue        <= '0;
                        req_reg.info.avg_green       <= '0;
                        req_reg.info.avg_red         <= '0;
                        req_reg.info.frame_done      <= (px_reg + XW'(1) == w_c) &&
                                                        (py_reg + YW'(1) == h_c);
                    end
                    if (px_reg + XW'(1) >= w_c)
                    begin
                        px_reg <= '0;
                        py_reg <= (py_reg + YW'(1) >= h_c) ? '0 : py_reg + YW'(1);
                    end
                    else
                        px_reg <= px_reg + XW'(1);
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign phase_busy = (state_reg != ST_IDLE);
    assign req_valid  = req_valid_reg;
    assign req        = req_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/bap_checker.sv =====
// Port-level checker for the block-average pixelation stage, bound to the top level.
`default_nettype none
module bap_port_checks (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            pix_valid,
    input wire logic            pix_stall,
    input wire logic            blk_valid,
    input wire logic            blk_stall,
    input wire bap_pkg::block_t blk
);
    a_blk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && blk_stall |=> blk_valid && $stable(blk))
        else $error("result changed while stalled");

    a_width_ok: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid |-> blk.block_width != 7'd0 && blk.block_height != 7'd0)
        else $error("zero block extent");

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid |-> pix_stall)
        else $error("pixel taken while a result is pending");

    a_one_cycle_gap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall |=> pix_stall)
        else $error("pixel taken on consecutive cycles");
endmodule

bind block_average_pixelation bap_port_checks u_bap_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .blk_valid(blk_valid),
    .blk_stall(blk_stall),
    .blk      (blk)
);
`default_nettype wire
